/* rtl/tnbm_pkg.sv */
// ----------------------------------------------------------------------------
// tnbm_pkg
// Shared types, codes and constant functions of the trainable tanh neuron.
// ----------------------------------------------------------------------------
package tnbm_pkg;

	// default sizes
	localparam int MAX_INPUTS_DEF       = 64;
	localparam int TANH_TABLE_DEPTH_DEF = 1024;

	// configuration register indexes and reset values
	localparam logic       REG_LEARN_RATE = 1'b0;
	localparam logic       REG_MOMENTUM   = 1'b1;
	localparam logic [15:0] LEARN_RATE_RST = 16'd9830;
	localparam logic [15:0] MOMENTUM_RST   = 16'd32768;

	// request codes on req_type
	localparam logic [2:0] REQ_FWD   = 3'd0;
	localparam logic [2:0] REQ_OGRAD = 3'd1;
	localparam logic [2:0] REQ_HID   = 3'd2;
	localparam logic [2:0] REQ_UPD   = 3'd3;
	localparam logic [2:0] REQ_LOAD  = 3'd4;

	// result kinds
	localparam logic KIND_OUT  = 1'b0;
	localparam logic KIND_GRAD = 1'b1;

	typedef enum logic [2:0] {
		OP_FWD, OP_OGRAD, OP_HID, OP_UPD, OP_LOAD
	} op_t;

	// classified command from front to back
	typedef struct packed {
		op_t                op;
		logic [5:0]         idx;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               last;
	} cmd_t;

	// result item
	typedef struct packed {
		logic               kind;
		logic signed [15:0] value;
		logic               sat;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_ACC, ST_TANH, ST_ROM,
		ST_GRAD, ST_UPD_ND, ST_UPD_WR, ST_EMIT
	} bst_t;

	// unsigned restoring division, shift and subtract (elaboration only)
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-f in Q32 for f in Q32, 0 <= f < 1 (elaboration only)
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
		logic [63:0] e;
		logic [63:0] term;
		e    = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 24; k++) begin
			term = udiv((term * f) >> 32, 64'(k));
			e    = e + term;
		end
		return udiv(64'd1 << 63, e) << 1;
	endfunction

	// tanh at the center of bin i of [-8, 8), Q4.12 (elaboration only)
	function automatic logic [15:0] tanh_at(input int i, input int depth);
		logic [63:0] half, em1, m, num, n, f, p, t, mag, one;
		longint      d;
		one  = 64'd1 << 32;
		half = exp_neg_frac(64'd1 << 31);
		em1  = (half * half) >> 32;
		d    = 2 * longint'(i) + 1 - longint'(depth);
		m    = (d < 0) ? 64'(-d) : 64'(d);
		num  = 64'd16 * m;
		n    = udiv(num, 64'(depth));
		f    = udiv((num - n * 64'(depth)) << 32, 64'(depth));
		p    = one;
		for (logic [63:0] k = 0; k < n; k++) begin
			p = (p * em1) >> 32;
		end
		t   = (p * exp_neg_frac(f)) >> 32;
		mag = udiv(((one - t) << 12) + ((one + t) >> 1), one + t);
		return (d < 0) ? 16'(-mag) : 16'(mag);
	endfunction

endpackage

/* rtl/tnbm_front.sv */
// ----------------------------------------------------------------------------
// tnbm_front
// Accepts input items, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module tnbm_front import tnbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         req_type,
	input  logic [5:0]         elem_index,
	input  logic signed [15:0] first_value,
	input  logic signed [15:0] second_value,
	input  logic               last_elem,
	output logic               cmd_valid,
	output cmd_t               cmd,
	input  logic               cmd_pop
);

	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       known;
	logic       wr;
	cmd_t       c;

	// classify; unknown codes are taken and dropped
	always_comb begin
		known = 1'b1;
		c.op  = OP_FWD;
		unique case (req_type)
			REQ_FWD:   c.op = OP_FWD;
			REQ_OGRAD: c.op = OP_OGRAD;
			REQ_HID:   c.op = OP_HID;
			REQ_UPD:   c.op = OP_UPD;
			REQ_LOAD:  c.op = OP_LOAD;
			default:   known = 1'b0;
		endcase
		c.idx  = elem_index;
		c.a    = first_value;
		c.b    = second_value;
		c.last = last_elem;
	end

	assign full      = (cnt_q == 2'd2);
	assign wr        = push && !full && known;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	// two-entry command queue
	always_ff @(posedge clk) begin
		if (wr) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (cmd_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(cmd_pop);
		end
	end

endmodule

/* rtl/tnbm_rq.sv */
// ----------------------------------------------------------------------------
// tnbm_rq
// Two-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module tnbm_rq import tnbm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  res_t wdata,
	output logic rq_full,
	output logic empty,
	input  logic pop,
	output res_t rdata
);

	res_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign rq_full = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd      = pop && !empty;
	assign rdata   = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) q_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

/* rtl/tnbm_back.sv */
// ----------------------------------------------------------------------------
// tnbm_back
// Executes commands on one shared multiplier: weighted sum, tanh lookup,
// gradients and momentum weight update. Holds weights, deltas and registers.
// ----------------------------------------------------------------------------
module tnbm_back import tnbm_pkg::*; #(
	parameter int MAX_INPUTS       = MAX_INPUTS_DEF,
	parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        res_wr,
	output res_t        res,
	input  logic        rq_full
);

	localparam int IW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int TLOG = $clog2(TANH_TABLE_DEPTH);

	// rounding right shift, half away from zero
	function automatic logic signed [64:0] rnd(input logic signed [64:0] v, input int s);
		logic [64:0] m;
		m = v[64] ? 65'(-v) : 65'(v);
		m = (m + (65'd1 << (s - 1))) >> s;
		return v[64] ? -$signed(m) : $signed(m);
	endfunction

	// clamp to Q4.12, flag in the top bit
	function automatic logic [16:0] sat16(input logic signed [64:0] v);
		if (v > 65'sd32767) return {1'b1, 16'h7fff};
		if (v < -65'sd32768) return {1'b1, 16'h8000};
		return {1'b0, v[15:0]};
	endfunction

	bst_t st_q, st_d;

	// registers and state
	logic [15:0]        lr_q, mom_q;
	cmd_t               cur_q;
	logic signed [15:0] wrd_q, drd_q, out_q, grad_q, nd_q, val_q, rom_q;
	logic               dv_q;
	logic signed [15:0] drd_v;
	logic signed [64:0] prod_q, t1_q;
	logic signed [39:0] acc_q;
	logic               accc_q, sat_q;
	logic [TLOG-1:0]    raddr_q;
	logic [15:0]        wmem [MAX_INPUTS];
	logic [15:0]        dmem [MAX_INPUTS];
	logic [MAX_INPUTS-1:0] dval_q;
	logic [15:0]        rom [TANH_TABLE_DEPTH];

	// tanh table
	for (genvar g = 0; g < TANH_TABLE_DEPTH; g++) begin : g_rom
		localparam logic [15:0] E = tanh_at(g, TANH_TABLE_DEPTH);
		assign rom[g] = E;
	end

	logic [IW-1:0]      cadr, adr;
	logic               cok, ok;
	logic signed [32:0] ma;
	logic signed [31:0] mb, deriv;
	logic signed [40:0] asum;
	logic signed [39:0] anext;
	logic               aclamp;
	logic signed [64:0] q, wsum;
	logic [16:0]        gs, ns, ws;
	logic signed [28:0] s12;
	logic signed [39:0] sc;
	logic               tclamp;
	logic [27:0]        pos;

	assign cadr = IW'(cmd.idx);
	assign cok  = 32'(cmd.idx) < MAX_INPUTS;
	assign adr  = IW'(cur_q.idx);
	assign ok   = 32'(cur_q.idx) < MAX_INPUTS;

	// delta entries never written read as zero
	assign drd_v = dv_q ? drd_q : '0;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_LOAD:  st_d = ST_IDLE;
						OP_OGRAD: st_d = ST_MUL_B;
						default:  st_d = ST_MUL_A;
					endcase
				end
			end
			ST_MUL_A:  st_d = (cur_q.op == OP_UPD) ? ST_MUL_B : ST_ACC;
			ST_ACC: begin
				if (!cur_q.last) st_d = ST_IDLE;
				else st_d = (cur_q.op == OP_FWD) ? ST_TANH : ST_MUL_B;
			end
			ST_MUL_B:  st_d = ST_MUL_C;
			ST_MUL_C:  st_d = (cur_q.op == OP_UPD) ? ST_UPD_ND : ST_GRAD;
			ST_TANH:   st_d = ST_ROM;
			ST_ROM:    st_d = ST_EMIT;
			ST_GRAD:   st_d = ST_EMIT;
			ST_UPD_ND: st_d = ST_UPD_WR;
			ST_UPD_WR: st_d = ST_IDLE;
			ST_EMIT:   st_d = rq_full ? ST_EMIT : ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// handshake strobes
	always_comb begin
		cmd_pop = (st_q == ST_IDLE) && cmd_valid;
		res_wr  = (st_q == ST_EMIT) && !rq_full;
	end

	assign res.kind  = (cur_q.op == OP_FWD) ? KIND_OUT : KIND_GRAD;
	assign res.value = (cur_q.op == OP_FWD) ? rom_q : val_q;
	assign res.sat   = sat_q;

	// shared multiplier operand select
	assign deriv = 32'sd16777216 - $signed(prod_q[31:0]);
	assign s12   = 29'(rnd(65'(acc_q), 12));
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			ST_MUL_A: begin
				case (cur_q.op)
					OP_FWD: begin
						ma = ok ? 33'(wrd_q) : '0;
						mb = 32'(cur_q.a);
					end
					OP_HID: begin
						ma = 33'(cur_q.a);
						mb = 32'(cur_q.b);
					end
					default: begin
						ma = $signed({17'd0, lr_q});
						mb = 32'(cur_q.a);
					end
				endcase
			end
			ST_MUL_B: begin
				if (cur_q.op == OP_UPD) begin
					ma = prod_q[32:0];
					mb = 32'(grad_q);
				end else begin
					ma = 33'(out_q);
					mb = 32'(out_q);
				end
			end
			ST_MUL_C: begin
				case (cur_q.op)
					OP_UPD: begin
						ma = $signed({17'd0, mom_q});
						mb = 32'(drd_v);
					end
					OP_HID: begin
						ma = 33'(s12);
						mb = deriv;
					end
					default: begin
						ma = 33'(cur_q.a) - 33'(out_q);
						mb = deriv;
					end
				endcase
			end
			default: ;
		endcase
	end

	// accumulator add with clamp
	always_comb begin
		asum   = 41'(acc_q) + 41'($signed(prod_q[31:0]));
		aclamp = 1'b0;
		anext  = asum[39:0];
		if (asum > 41'sd549755813887) begin
			anext  = 40'sh7f_ffff_ffff;
			aclamp = 1'b1;
		end else if (asum < -41'sd549755813888) begin
			anext  = 40'sh80_0000_0000;
			aclamp = 1'b1;
		end
	end

	// sum clamp to [-8, 8) and table index
	always_comb begin
		sc     = acc_q;
		tclamp = 1'b0;
		if (acc_q > 40'sd134217727) begin
			sc     = 40'sd134217727;
			tclamp = 1'b1;
		end else if (acc_q < -40'sd134217728) begin
			sc     = -40'sd134217728;
			tclamp = 1'b1;
		end
		pos = 28'(sc + 40'sd134217728);
	end

	assign gs   = sat16(rnd(prod_q, 24));
	assign q    = t1_q + (prod_q <<< 12);
	assign ns   = sat16(rnd(q, 28));
	assign wsum = 65'(wrd_q) + 65'(nd_q);
	assign ws   = sat16(wsum);

	// weight memory
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid) wrd_q <= wmem[cadr];
		if (st_q == ST_IDLE && cmd_valid && cmd.op == OP_LOAD && cok)
			wmem[cadr] <= cmd.b;
		else if (st_q == ST_UPD_WR && ok)
			wmem[adr] <= ws[15:0];
	end

	// delta memory
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid) drd_q <= dmem[cadr];
		if (st_q == ST_UPD_ND && ok) dmem[adr] <= ns[15:0];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid) cur_q <= cmd;
		prod_q <= ma * mb;
		if (st_q == ST_MUL_C) t1_q <= prod_q;
		if (st_q == ST_TANH) raddr_q <= pos[27 -: TLOG];
		if (st_q == ST_ROM) rom_q <= rom[raddr_q];
		if (st_q == ST_GRAD) val_q <= gs[15:0];
		if (st_q == ST_UPD_ND) nd_q <= ns[15:0];
	end

	// control state, registers, valid bits and neuron state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			lr_q   <= LEARN_RATE_RST;
			mom_q  <= MOMENTUM_RST;
			dval_q <= '0;
			dv_q   <= 1'b0;
			acc_q  <= '0;
			accc_q <= 1'b0;
			out_q  <= '0;
			grad_q <= '0;
			sat_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_LEARN_RATE: lr_q  <= cfg_wdata;
					REG_MOMENTUM:   mom_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (st_q == ST_IDLE && cmd_valid) dv_q <= dval_q[cadr];
			if (st_q == ST_ACC) begin
				acc_q  <= anext;
				accc_q <= accc_q | aclamp;
			end
			if (st_q == ST_TANH) begin
				sat_q  <= accc_q | tclamp;
				acc_q  <= '0;
				accc_q <= 1'b0;
			end
			if (st_q == ST_GRAD) begin
				sat_q  <= gs[16] | ((cur_q.op == OP_HID) & accc_q);
				grad_q <= gs[15:0];
				if (cur_q.op == OP_HID) begin
					acc_q  <= '0;
					accc_q <= 1'b0;
				end
			end
			if (st_q == ST_UPD_ND && ok) dval_q[adr] <= 1'b1;
			if (res_wr && cur_q.op == OP_FWD) out_q <= rom_q;
		end
	end

endmodule

/* rtl/tanh_neuron_backprop_momentum.sv */
// ----------------------------------------------------------------------------
// tanh_neuron_backprop_momentum
// Trainable tanh neuron with backpropagation and momentum, Q4.12 datapath.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// input     in         push / full            req_type elem_index first_value
//                                             second_value last_elem
// result    out        empty / pop            result_kind result_value saturated
// config    in         cfg_we                 cfg_addr cfg_wdata
//
// The back end finishes each command before it takes the next, all on one multiplier.
// A two-entry command queue lets input transfers go on while the back end works.
// Reset empties queues and accumulator, presets registers, clears delta valid bits.
// The back end stalls in its emit step while the result queue is full.
// ----------------------------------------------------------------------------
module tanh_neuron_backprop_momentum import tnbm_pkg::*; #(
	parameter int MAX_INPUTS       = MAX_INPUTS_DEF,
	parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         req_type,
	input  logic [5:0]         elem_index,
	input  logic signed [15:0] first_value,
	input  logic signed [15:0] second_value,
	input  logic               last_elem,
	output logic               empty,
	input  logic               pop,
	output logic               result_kind,
	output logic signed [15:0] result_value,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [15:0]        cfg_wdata
);

	logic cmd_valid, cmd_pop, res_wr, rq_full;
	cmd_t cmd;
	res_t res, rdata;

	tnbm_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .elem_index, .first_value,
		.second_value, .last_elem, .cmd_valid, .cmd, .cmd_pop
	);

	tnbm_back #(
		.MAX_INPUTS(MAX_INPUTS), .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
	) u_back (
		.clk, .arst_n, .cfg_we, .cfg_addr, .cfg_wdata, .cmd_valid, .cmd,
		.cmd_pop, .res_wr, .res, .rq_full
	);

	tnbm_rq u_rq (
		.clk, .arst_n, .wr(res_wr), .wdata(res), .rq_full, .empty, .pop, .rdata
	);

	assign result_kind  = rdata.kind;
	assign result_value = rdata.value;
	assign saturated    = rdata.sat;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the trainable tanh neuron: a directed table covering the edge cases,
// then random forward, hidden, gradient, update and load streams under several
// learning-rate and momentum settings, scored by an in-bench model or typed row.
// ----------------------------------------------------------------------------
module testbench;
	import tnbm_pkg::*;

	localparam logic [2:0] REQ_UNUSED_MIN = 3'd5;
	localparam logic [2:0] REQ_UNUSED_MAX = 3'd7;
	localparam int         NUM_W          = 64;
	localparam int         ROM_DEPTH      = 1024;
	localparam longint     ACC_HI         = (64'sd1 <<< 39) - 1;
	localparam longint     ACC_LO         = -(64'sd1 <<< 39);
	localparam longint     SUM_HI         = (64'sd1 <<< 27) - 1;
	localparam longint     SUM_LO         = -(64'sd1 <<< 27);
	localparam int         PHASE_ITEMS    = 340;

	typedef struct packed {
		logic [2:0]         typ;
		logic [5:0]         idx;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               last;
	} req_t;

	typedef struct packed {
		req_t               req;
		logic               typed;
		logic               ekind;
		logic signed [15:0] evalue;
		logic               esat;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [2:0]         req_type;
	logic [5:0]         elem_index;
	logic signed [15:0] first_value;
	logic signed [15:0] second_value;
	logic               last_elem;
	logic               empty;
	logic               pop;
	logic               result_kind;
	logic signed [15:0] result_value;
	logic               saturated;
	logic               cfg_we;
	logic               cfg_addr;
	logic [15:0]        cfg_wdata;

	// neuron model state
	logic signed [15:0] tanh_lut [ROM_DEPTH];
	logic signed [15:0] weights [NUM_W];
	logic signed [15:0] deltas [NUM_W];
	longint             acc_sum;
	logic               acc_sat;
	logic signed [15:0] neuron_out;
	logic signed [15:0] neuron_grad;
	logic [15:0]        eta;
	logic [15:0]        alpha;

	res_t pending_results[$];
	int   fail_count;
	bit   no_idle;

	// directed table: typed expectations only where obvious
	row_t dir_table [22] = '{
		'{'{REQ_LOAD, 6'd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_FWD, 6'd0, 16'sd32767, 16'sd0, 1'b1}, 1'b1, KIND_OUT, 16'sd32, 1'b0},
		'{'{REQ_OGRAD, 6'd0, 16'sd0, 16'sd0, 1'b0}, 1'b1, KIND_GRAD, -16'sd32, 1'b0},
		'{'{REQ_LOAD, 6'd63, 16'sd0, 16'sd32767, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_LOAD, 6'd1, 16'sd0, -16'sd32768, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_FWD, 6'd63, 16'sd32767, 16'sd0, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_FWD, 6'd63, 16'sd32767, 16'sd0, 1'b1}, 1'b1, KIND_OUT, 16'sd4096, 1'b1},
		'{'{REQ_OGRAD, 6'd0, -16'sd32768, 16'sd0, 1'b0}, 1'b1, KIND_GRAD, 16'sd0, 1'b0},
		'{'{REQ_OGRAD, 6'd5, 16'sd32767, 16'sd0, 1'b1}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_FWD, 6'd1, -16'sd32768, 16'sd0, 1'b1}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_HID, 6'd0, 16'sd32767, 16'sd32767, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_HID, 6'd1, -16'sd32768, -16'sd32768, 1'b1}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_UPD, 6'd63, 16'sd32767, 16'sd0, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_UPD, 6'd1, -16'sd32768, 16'sd0, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_UNUSED_MIN, 6'd63, -16'sd1, 16'sd1, 1'b1}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_UNUSED_MAX, 6'd0, 16'sd0, -16'sd1, 1'b1}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_FWD, 6'd63, 16'sd4096, 16'sd0, 1'b1}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_OGRAD, 6'd0, 16'sd1234, 16'sd0, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_UPD, 6'd0, 16'sd2048, 16'sd0, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_LOAD, 6'd62, 16'sd0, -16'sd1, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_FWD, 6'd0, 16'sd100, 16'sd0, 1'b0}, 1'b0, KIND_OUT, 16'sd0, 1'b0},
		'{'{REQ_HID, 6'd2, 16'sd5, 16'sd5, 1'b1}, 1'b0, KIND_OUT, 16'sd0, 1'b0}
	};

	tanh_neuron_backprop_momentum u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.elem_index   (elem_index),
		.first_value  (first_value),
		.second_value (second_value),
		.last_elem    (last_elem),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.result_value (result_value),
		.saturated    (saturated),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// e^-f in Q32, 0 <= f < 1, by power series
	function automatic longint unsigned exp_neg_q32(input longint unsigned f);
		longint unsigned e;
		longint unsigned term;
		e    = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * f) >> 32) / longint'(k);
			e    = e + term;
		end
		return ((64'd1 << 63) / e) << 1;
	endfunction

	task automatic fill_tanh_lut();
		longint unsigned one, half, em1, m, num, n, f, p, t, mag;
		longint          d;
		one  = 64'd1 << 32;
		half = exp_neg_q32(64'd1 << 31);
		em1  = (half * half) >> 32;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			d   = 2 * longint'(i) + 1 - ROM_DEPTH;
			m   = (d < 0) ? -d : d;
			num = 16 * m;
			n   = num / ROM_DEPTH;
			f   = ((num % ROM_DEPTH) << 32) / ROM_DEPTH;
			p   = one;
			for (longint unsigned k = 0; k < n; k++)
				p = (p * em1) >> 32;
			t   = (p * exp_neg_q32(f)) >> 32;
			mag = (((one - t) << 12) + (one + t) / 2) / (one + t);
			tanh_lut[i] = (d < 0) ? -16'(mag) : 16'(mag);
		end
	endtask

	// shift right, rounding half away from zero
	function automatic longint shr_round(input longint v, input int s);
		longint unsigned mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic signed [15:0] clamp_q12(input longint v, inout logic flag);
		if (v > 32767) begin
			flag = 1'b1;
			return 16'sd32767;
		end
		if (v < -32768) begin
			flag = 1'b1;
			return -16'sd32768;
		end
		return 16'(v);
	endfunction

	task automatic accumulate(input longint p);
		longint s;
		s = acc_sum + p;
		if (s > ACC_HI) begin
			s       = ACC_HI;
			acc_sat = 1'b1;
		end
		if (s < ACC_LO) begin
			s       = ACC_LO;
			acc_sat = 1'b1;
		end
		acc_sum = s;
	endtask

	// one request through the neuron model; got is set when a result follows
	task automatic neuron_step(input req_t r, output bit got, output res_t res);
		longint a, b, s, deriv, q;
		logic   sat;
		a     = r.a;
		b     = r.b;
		sat   = 1'b0;
		got   = 1'b0;
		res   = '0;
		deriv = (64'sd1 <<< 24) - longint'(neuron_out) * longint'(neuron_out);
		case (r.typ)
			REQ_FWD: begin
				accumulate(longint'(weights[r.idx]) * a);
				if (r.last) begin
					s   = acc_sum;
					sat = acc_sat;
					if (s > SUM_HI) begin
						s   = SUM_HI;
						sat = 1'b1;
					end
					if (s < SUM_LO) begin
						s   = SUM_LO;
						sat = 1'b1;
					end
					neuron_out = tanh_lut[((s - SUM_LO) * ROM_DEPTH) >>> 28];
					acc_sum    = 0;
					acc_sat    = 1'b0;
					got        = 1'b1;
					res        = '{KIND_OUT, neuron_out, sat};
				end
			end
			REQ_OGRAD: begin
				neuron_grad = clamp_q12(shr_round((a - neuron_out) * deriv, 24), sat);
				got         = 1'b1;
				res         = '{KIND_GRAD, neuron_grad, sat};
			end
			REQ_HID: begin
				accumulate(a * b);
				if (r.last) begin
					sat         = acc_sat;
					s           = shr_round(acc_sum, 12);
					neuron_grad = clamp_q12(shr_round(s * deriv, 24), sat);
					acc_sum     = 0;
					acc_sat     = 1'b0;
					got         = 1'b1;
					res         = '{KIND_GRAD, neuron_grad, sat};
				end
			end
			REQ_UPD: begin
				q = longint'(eta) * a * longint'(neuron_grad)
					+ longint'(alpha) * longint'(deltas[r.idx]) * 4096;
				deltas[r.idx]  = clamp_q12(shr_round(q, 28), sat);
				weights[r.idx] = clamp_q12(longint'(weights[r.idx]) + deltas[r.idx], sat);
			end
			REQ_LOAD: weights[r.idx] = r.b;
			default: ;
		endcase
	endtask

	task automatic note_failure(input string msg);
		if (fail_count < 10)
			$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// present one request and hold it until its transfer
	task automatic send_req(input req_t r, input bit typed, input res_t typed_res);
		int   gap;
		bit   got;
		res_t res;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push         <= 1'b1;
		req_type     <= r.typ;
		elem_index   <= r.idx;
		first_value  <= r.a;
		second_value <= r.b;
		last_elem    <= r.last;
		do @(posedge clk); while (full);
		neuron_step(r, got, res);
		if (got)
			pending_results.insert(pending_results.size(), typed ? typed_res : res);
		@(negedge clk);
	endtask

	task automatic send_rand(input req_t r);
		send_req(r, 1'b0, '0);
	endtask

	// hold off until every result is back and the back end has settled
	task automatic drain();
		push <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_regs(input logic [15:0] lr, input logic [15:0] mom);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_LEARN_RATE;
		cfg_wdata <= lr;
		@(negedge clk);
		cfg_addr  <= REG_MOMENTUM;
		cfg_wdata <= mom;
		@(negedge clk);
		cfg_we    <= 1'b0;
		eta   = lr;
		alpha = mom;
	endtask

	function automatic logic signed [15:0] rand_q12();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 8192)) - 4096);
	endfunction

	// one random sequence; returns the number of requests sent
	task automatic random_sequence(output int sent);
		req_t r;
		int   pick, len;
		pick = $urandom_range(0, 99);
		len  = $urandom_range(1, 6);
		sent = 0;
		if (pick < 28 || (pick >= 40 && pick < 55)) begin
			// forward or hidden stream
			for (int i = 0; i < len; i++) begin
				r.typ  = (pick < 28) ? REQ_FWD : REQ_HID;
				r.idx  = 6'($urandom);
				r.a    = rand_q12();
				r.b    = rand_q12();
				r.last = (i == len - 1);
				send_rand(r);
				sent++;
			end
		end else begin
			for (int i = 0; i < ((pick >= 55 && pick < 75) ? len : 1); i++) begin
				r.idx  = 6'($urandom);
				r.a    = rand_q12();
				r.b    = rand_q12();
				r.last = 1'($urandom);
				if (pick < 40)
					r.typ = REQ_OGRAD;
				else if (pick < 75)
					r.typ = REQ_UPD;
				else if (pick < 85)
					r.typ = REQ_LOAD;
				else if (pick < 90)
					r.typ = 3'($urandom_range(REQ_UNUSED_MIN, REQ_UNUSED_MAX));
				else
					r.typ = 3'($urandom_range(REQ_FWD, REQ_LOAD));
				send_rand(r);
				sent++;
			end
		end
	endtask

	// result side: random pop with short and long stalls
	initial begin
		int hold, r;
		pop  = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= 1'b1;
				r = $urandom_range(0, 99);
				if (!no_idle && r < 25)
					hold = $urandom_range(1, 3);
				else if (!no_idle && r < 30)
					hold = $urandom_range(15, 50);
			end
		end
	end

	// score each result transfer against the oldest expectation
	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result kind %0d value %0d sat %0d",
					result_kind, result_value, saturated));
			end else begin
				exp_res = pending_results.pop_front();
				if (result_kind !== exp_res.kind || result_value !== exp_res.value
						|| saturated !== exp_res.sat)
					note_failure($sformatf("exp kind %0d value %0d sat %0d, got %0d %0d %0d",
						exp_res.kind, exp_res.value, exp_res.sat,
						result_kind, result_value, saturated));
			end
		end
	end

	initial begin
		req_t            r;
		int              sent, count;
		logic [15:0]     lr_set [5];
		logic [15:0]     mom_set [5];
		arst_n       = 1'b0;
		push         = 1'b0;
		req_type     = REQ_FWD;
		elem_index   = '0;
		first_value  = '0;
		second_value = '0;
		last_elem    = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = REG_LEARN_RATE;
		cfg_wdata    = '0;
		fail_count   = 0;
		no_idle      = 1'b0;
		fill_tanh_lut();
		for (int i = 0; i < NUM_W; i++) begin
			weights[i] = '0;
			deltas[i]  = '0;
		end
		acc_sum     = 0;
		acc_sat     = 1'b0;
		neuron_out  = '0;
		neuron_grad = '0;
		eta         = LEARN_RATE_RST;
		alpha       = MOMENTUM_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table at reset settings
		foreach (dir_table[i])
			send_req(dir_table[i].req, dir_table[i].typed,
				'{dir_table[i].ekind, dir_table[i].evalue, dir_table[i].esat});
		drain();

		lr_set  = '{16'd0, 16'd65535, LEARN_RATE_RST, 16'($urandom), 16'd65535};
		mom_set = '{16'd0, 16'd65535, MOMENTUM_RST, 16'($urandom), 16'd0};
		for (int ph = 0; ph < 5; ph++) begin
			write_regs(lr_set[ph], mom_set[ph]);
			no_idle = (ph == 2);
			count   = 0;
			// fresh weights so that no unwritten entry is ever read
			if (ph == 0) begin
				for (int i = 0; i < NUM_W; i++) begin
					r = '{REQ_LOAD, 6'(i), 16'sd0, rand_q12(), 1'b0};
					send_rand(r);
					count++;
				end
			end
			// accumulator overflow: a long run of the largest products
			if (ph == 1) begin
				for (int i = 0; i < 520; i++) begin
					r = '{REQ_HID, 6'(i), -16'sd32768, -16'sd32768, (i == 519)};
					send_rand(r);
					count++;
				end
			end
			while (count < PHASE_ITEMS) begin
				random_sequence(sent);
				count += sent;
			end
			drain();
		end

		no_idle = 1'b0;
		if (fail_count == 0 && pending_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
